>>> sv/two_wire_humidity_sensor_master_unit_defines.svh
// Assertion macros for the two-wire sensor master
`ifndef TWO_WIRE_HUMIDITY_SENSOR_MASTER_UNIT_DEFINES_SVH
`define TWO_WIRE_HUMIDITY_SENSOR_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define TWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define TWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tws_pkg.sv
package tws_pkg;

  // Reset value of the timeout register (ticks)
  localparam logic [15:0] TimeoutReset = 16'd1000;

  // Bit-phase sequencer states
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_TS0,
    PH_TS1,
    PH_TS2,
    PH_TS3,
    PH_TS4,
    PH_CMD_LO,
    PH_CMD_HI,
    PH_ACK_HI,
    PH_ACK_LO,
    PH_WAIT,
    PH_RD_HI,
    PH_RD_LO,
    PH_MACK_D,
    PH_MACK_HI,
    PH_MACK_LO,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_e;

  // One tick request
  typedef struct packed {
    logic       start_req;
    logic [7:0] command;
    logic       data_in;
  } tick_t;

  // One tick result
  typedef struct packed {
    logic        clock_level;
    logic        data_enable;
    logic        data_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] value;
    logic        timed_out;
  } res_t;

endpackage

>>> sv/tws_fsm.sv
module tws_fsm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  tws_pkg::tick_t tick_i,
  input  logic [15:0]    timeout_ticks_i,
  output tws_pkg::res_t  res_o
);

  tws_pkg::phase_e phase_q, phase_d, phase_eff;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [15:0] shift_q, shift_d;
  logic [15:0] wait_q, wait_d;
  logic [7:0]  cmd_q, cmd_d;
  logic        tmo_q, tmo_d;
  logic        start;
  logic        cmd_bit;
  logic [16:0] limit;
  logic        wait_expired;

  // A start request is only honoured when idle
  assign start     = (phase_q == tws_pkg::PH_IDLE) && tick_i.start_req;
  assign phase_eff = start ? tws_pkg::PH_TS0 : phase_q;

  // Command bit, MSB first
  assign cmd_bit = cmd_q[3'd7 - bit_idx_q[2:0]];

  // Zero timeout behaves as one sample
  assign limit = (timeout_ticks_i == 16'd0) ? 17'd1 : {1'b0, timeout_ticks_i};
  assign wait_expired = ({1'b0, wait_q} + 17'd1) >= limit;

  // Next state
  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    wait_d    = wait_q;
    cmd_d     = cmd_q;
    tmo_d     = tmo_q;
    if (start) begin
      cmd_d     = tick_i.command;
      bit_idx_d = 4'd0;
      shift_d   = 16'd0;
      wait_d    = 16'd0;
      tmo_d     = 1'b0;
    end
    case (phase_eff)
      tws_pkg::PH_TS0: phase_d = tws_pkg::PH_TS1;
      tws_pkg::PH_TS1: phase_d = tws_pkg::PH_TS2;
      tws_pkg::PH_TS2: phase_d = tws_pkg::PH_TS3;
      tws_pkg::PH_TS3: phase_d = tws_pkg::PH_TS4;
      tws_pkg::PH_TS4: begin
        bit_idx_d = 4'd0;
        phase_d   = tws_pkg::PH_CMD_LO;
      end
      tws_pkg::PH_CMD_LO: phase_d = tws_pkg::PH_CMD_HI;
      tws_pkg::PH_CMD_HI: begin
        if (bit_idx_q[2:0] == 3'd7) begin
          bit_idx_d = 4'd0;
          phase_d   = tws_pkg::PH_ACK_HI;
        end else begin
          bit_idx_d = bit_idx_q + 4'd1;
          phase_d   = tws_pkg::PH_CMD_LO;
        end
      end
      tws_pkg::PH_ACK_HI: phase_d = tws_pkg::PH_ACK_LO;
      tws_pkg::PH_ACK_LO: begin
        wait_d  = 16'd0;
        phase_d = tws_pkg::PH_WAIT;
      end
      tws_pkg::PH_WAIT: begin
        if (!tick_i.data_in) begin
          bit_idx_d = 4'd0;
          phase_d   = tws_pkg::PH_RD_HI;
        end else if (wait_expired) begin
          tmo_d     = 1'b1;
          bit_idx_d = 4'd0;
          phase_d   = tws_pkg::PH_RD_HI;
        end else begin
          wait_d = wait_q + 16'd1;
        end
      end
      tws_pkg::PH_RD_HI: begin
        shift_d = {shift_q[14:0], tick_i.data_in};
        phase_d = tws_pkg::PH_RD_LO;
      end
      tws_pkg::PH_RD_LO: begin
        if (bit_idx_q == 4'd7) begin
          bit_idx_d = 4'd8;
          phase_d   = tws_pkg::PH_MACK_D;
        end else if (bit_idx_q == 4'd15) begin
          phase_d = tws_pkg::PH_CRC_HI;
        end else begin
          bit_idx_d = bit_idx_q + 4'd1;
          phase_d   = tws_pkg::PH_RD_HI;
        end
      end
      tws_pkg::PH_MACK_D:  phase_d = tws_pkg::PH_MACK_HI;
      tws_pkg::PH_MACK_HI: phase_d = tws_pkg::PH_MACK_LO;
      tws_pkg::PH_MACK_LO: phase_d = tws_pkg::PH_RD_HI;
      tws_pkg::PH_CRC_HI:  phase_d = tws_pkg::PH_CRC_LO;
      default:             phase_d = tws_pkg::PH_IDLE;
    endcase
  end

  // Line levels and status for this tick
  always_comb begin
    res_o             = '0;
    res_o.busy_res    = 1'b1;
    case (phase_eff)
      tws_pkg::PH_TS0: begin
        res_o.clock_level = 1'b1;
        res_o.data_enable = 1'b1;
        res_o.data_level  = 1'b1;
      end
      tws_pkg::PH_TS1: begin
        res_o.clock_level = 1'b1;
        res_o.data_enable = 1'b1;
      end
      tws_pkg::PH_TS2: res_o.data_enable = 1'b1;
      tws_pkg::PH_TS3: begin
        res_o.clock_level = 1'b1;
        res_o.data_enable = 1'b1;
        res_o.data_level  = 1'b1;
      end
      tws_pkg::PH_TS4: begin
        res_o.data_enable = 1'b1;
        res_o.data_level  = 1'b1;
      end
      tws_pkg::PH_CMD_LO: begin
        res_o.data_enable = 1'b1;
        res_o.data_level  = cmd_bit;
      end
      tws_pkg::PH_CMD_HI: begin
        res_o.clock_level = 1'b1;
        res_o.data_enable = 1'b1;
        res_o.data_level  = cmd_bit;
      end
      tws_pkg::PH_ACK_HI:  res_o.clock_level = 1'b1;
      tws_pkg::PH_ACK_LO:  res_o.clock_level = 1'b0;
      tws_pkg::PH_WAIT:    res_o.clock_level = 1'b0;
      tws_pkg::PH_RD_HI:   res_o.clock_level = 1'b1;
      tws_pkg::PH_RD_LO:   res_o.clock_level = 1'b0;
      tws_pkg::PH_MACK_D:  res_o.data_enable = 1'b1;
      tws_pkg::PH_MACK_HI: begin
        res_o.clock_level = 1'b1;
        res_o.data_enable = 1'b1;
      end
      tws_pkg::PH_MACK_LO: res_o.data_enable = 1'b1;
      tws_pkg::PH_CRC_HI: begin
        res_o.clock_level = 1'b1;
        res_o.data_enable = 1'b1;
        res_o.data_level  = 1'b1;
      end
      tws_pkg::PH_CRC_LO: begin
        res_o.data_enable = 1'b1;
        res_o.data_level  = 1'b1;
        res_o.done_res    = 1'b1;
        res_o.value       = shift_q;
        res_o.timed_out   = tmo_q;
      end
      default: res_o.busy_res = 1'b0;
    endcase
  end

  // Sequencer state, advanced once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tws_pkg::PH_IDLE;
      bit_idx_q <= 4'd0;
      shift_q   <= 16'd0;
      wait_q    <= 16'd0;
      cmd_q     <= 8'd0;
      tmo_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      wait_q    <= wait_d;
      cmd_q     <= cmd_d;
      tmo_q     <= tmo_d;
    end
  end

endmodule

>>> sv/two_wire_humidity_sensor_master_unit.sv
// Two-wire humidity/temperature sensor master, one bit-phase tick per request.
// Tick channel (in_valid_i/in_ready_o): start_req_i, command_i, data_in_i.
// Result channel (out_valid_o/out_ready_i): one result per tick with the
// clock, data enable and data levels to drive, busy/done, the 16-bit value
// and the timeout flag.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): timeout in ticks,
// always ready; write it only while no measurement is running.
// A tick is registered in the input register, stepped through the
// sequencer and its result is captured in the output register.
// Throughput: one tick per cycle while the result channel does not stall.
// A stalled receiver holds the result; the input register still takes a
// request while the result waits, then back-pressure stops the channel.
// Reset: sequencer idle, both registers empty, timeout back to 1000 ticks.
`include "two_wire_humidity_sensor_master_unit_defines.svh"

module two_wire_humidity_sensor_master_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  input  logic [7:0]  command_i,
  input  logic        data_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        clock_level_o,
  output logic        data_enable_o,
  output logic        data_level_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [15:0] value_o,
  output logic        timed_out_o
);

  logic           in_valid_q;
  tws_pkg::tick_t tick_q;
  logic           out_valid_q;
  tws_pkg::res_t  res_q, res_d;
  logic [15:0]    timeout_q;
  logic           advance;

  // Timeout register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tws_pkg::TimeoutReset;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // Move a request on when the result slot is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tick_q <= '{start_req: start_req_i, command: command_i, data_in: data_in_i};
    end
  end

  // Sequencer
  tws_fsm u_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .tick_i          (tick_q),
    .timeout_ticks_i (timeout_q),
    .res_o           (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign clock_level_o = res_q.clock_level;
  assign data_enable_o = res_q.data_enable;
  assign data_level_o  = res_q.data_level;
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign value_o       = res_q.value;
  assign timed_out_o   = res_q.timed_out;

  // Checks
  `TWS_ASSERT_NOW(a_done_busy, out_valid_o && done_res_o, busy_res_o, "done without busy")
  `TWS_ASSERT_NOW(a_rel_low, out_valid_o && !data_enable_o, !data_level_o, "level on released line")
  `TWS_ASSERT_NOW(a_idle_quiet, out_valid_o && !busy_res_o, !clock_level_o && !data_enable_o, "lines active when idle")
  `TWS_ASSERT_NEXT(a_stall_hold, in_valid_q && out_valid_q && !out_ready_i, in_valid_q, "request lost in stall")

endmodule
